// File: hdl/sxcd_pkg.sv
// ----------------------------------------------------------------------------
// sxcd_pkg
// Shared types, register codes and arithmetic helpers for the stereo
// cross-feedback comb delay.
// ----------------------------------------------------------------------------
package sxcd_pkg;

   localparam int SAMPLE_W           = 24;
   localparam int COEF_W             = 16;
   localparam int FRAC_W             = 14;
   localparam int PROD_W             = SAMPLE_W + COEF_W;
   localparam int ACC_W              = PROD_W + 2;
   localparam int DELAY_W            = 12;
   localparam int CSR_INDEX_W        = 4;
   localparam int CSR_DATA_W         = 32;
   localparam int LINE_DEPTH_DEFAULT = 4096;

   localparam int HALF_LSB   = 8192;
   localparam int SAMPLE_MAX = 8388607;
   localparam int SAMPLE_MIN = -8388608;

   localparam logic [DELAY_W-1:0]    DELAY_RESET    = DELAY_W'(1);
   localparam logic [COEF_W-1:0]     BLEND_RESET    = '0;
   localparam logic [CSR_DATA_W-1:0] FB_RESET       = '0;
   localparam logic [CSR_DATA_W-1:0] FF_LEFT_RESET  = 32'h4000_0000;
   localparam logic [CSR_DATA_W-1:0] FF_RIGHT_RESET = 32'h0000_4000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELAY_LEFT  = 4'd0,
      CSR_DELAY_RIGHT = 4'd1,
      CSR_BLEND_LEFT  = 4'd2,
      CSR_BLEND_RIGHT = 4'd3,
      CSR_FB_LEFT     = 4'd4,
      CSR_FB_RIGHT    = 4'd5,
      CSR_FF_LEFT     = 4'd6,
      CSR_FF_RIGHT    = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [DELAY_W-1:0]    delay_left;
      logic [DELAY_W-1:0]    delay_right;
      coef_type              blend_left;
      coef_type              blend_right;
      logic [CSR_DATA_W-1:0] fb_left;
      logic [CSR_DATA_W-1:0] fb_right;
      logic [CSR_DATA_W-1:0] ff_left;
      logic [CSR_DATA_W-1:0] ff_right;
   } cfg_type;

   typedef struct packed {
      sample_type in_left;
      sample_type in_right;
   } req_type;

   typedef struct packed {
      sample_type out_left;
      sample_type out_right;
   } rsp_type;

   // upper coefficient of a packed pair: weight of the delayed left value
   function automatic coef_type coef_hi(input logic [CSR_DATA_W-1:0] pair);
      return $signed(pair[2*COEF_W-1:COEF_W]);
   endfunction

   function automatic coef_type coef_lo(input logic [CSR_DATA_W-1:0] pair);
      return $signed(pair[COEF_W-1:0]);
   endfunction

   // round half up out of Q.14, then clamp to the sample range
   function automatic sample_type round_sat(input acc_type acc);
      acc_type                          biased;
      logic signed [ACC_W-FRAC_W-1:0] q;
      sample_type                       r;
      biased = acc + acc_type'(HALF_LSB);
      q      = biased[ACC_W-1:FRAC_W];
      if (q > SAMPLE_MAX) begin
         r = sample_type'(SAMPLE_MAX);
      end else if (q < SAMPLE_MIN) begin
         r = sample_type'(SAMPLE_MIN);
      end else begin
         r = q[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/sxcd_csr.sv
// ----------------------------------------------------------------------------
// sxcd_csr
// Configuration register file: tap distances, blend gains and the packed
// feedback and feedforward coefficient pairs.
// ----------------------------------------------------------------------------
module sxcd_csr import sxcd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_left  <= DELAY_RESET;
         cfg_ff.delay_right <= DELAY_RESET;
         cfg_ff.blend_left  <= BLEND_RESET;
         cfg_ff.blend_right <= BLEND_RESET;
         cfg_ff.fb_left     <= FB_RESET;
         cfg_ff.fb_right    <= FB_RESET;
         cfg_ff.ff_left     <= FF_LEFT_RESET;
         cfg_ff.ff_right    <= FF_RIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DELAY_LEFT:  cfg_ff.delay_left  <= csr_data[DELAY_W-1:0];
            CSR_DELAY_RIGHT: cfg_ff.delay_right <= csr_data[DELAY_W-1:0];
            CSR_BLEND_LEFT:  cfg_ff.blend_left  <= csr_data[COEF_W-1:0];
            CSR_BLEND_RIGHT: cfg_ff.blend_right <= csr_data[COEF_W-1:0];
            CSR_FB_LEFT:     cfg_ff.fb_left     <= csr_data;
            CSR_FB_RIGHT:    cfg_ff.fb_right    <= csr_data;
            CSR_FF_LEFT:     cfg_ff.ff_left     <= csr_data;
            CSR_FF_RIGHT:    cfg_ff.ff_right    <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

// File: hdl/sxcd_line_ram.sv
// ----------------------------------------------------------------------------
// sxcd_line_ram
// One delay line: simple dual-port memory, one write and one registered
// read per cycle, read returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module sxcd_line_ram import sxcd_pkg::*; #(
   parameter int DEPTH = LINE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  sample_type               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output sample_type               rd_data
);

   sample_type mem [DEPTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sxcd_tap_gen.sv
// ----------------------------------------------------------------------------
// sxcd_tap_gen
// Tap address for one line: tap distance reduced modulo the line depth by
// reciprocal multiplication, then subtracted from the write position.
// ----------------------------------------------------------------------------
module sxcd_tap_gen import sxcd_pkg::*; #(
   parameter int DEPTH = LINE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic [DELAY_W-1:0]       delay,
   input  logic [$clog2(DEPTH)-1:0] wp,
   output logic [$clog2(DEPTH)-1:0] tap
);

   localparam int     ADDR_W = $clog2(DEPTH);
   localparam int     SHIFT  = DELAY_W + ADDR_W;
   localparam longint RECIP  = ((longint'(1) << SHIFT) + DEPTH - 1) / DEPTH;
   localparam int     MUL_W  = DELAY_W + SHIFT;
   localparam int     REM_W  = DELAY_W + ADDR_W + 1;

   logic [MUL_W-1:0]   prod_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [DELAY_W-1:0] quot;
   logic [REM_W-1:0]   rem_full;
   logic [ADDR_W-1:0]  tap_dist;
   logic [ADDR_W:0]    diff;
   logic [ADDR_W:0]    wrapped;

   // quotient is exact for every 12-bit distance at this shift
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff  <= MUL_W'(delay) * MUL_W'(RECIP);
         delay_ff <= delay;
      end
   end

   always_comb begin
      quot     = prod_ff[MUL_W-1:SHIFT];
      rem_full = REM_W'(delay_ff) - REM_W'(quot) * REM_W'(DEPTH);
      tap_dist = rem_full[ADDR_W-1:0];
      diff     = {1'b0, wp} - {1'b0, tap_dist};
      wrapped  = diff + (ADDR_W+1)'(DEPTH);
      if (tap_dist > wp) begin
         tap = wrapped[ADDR_W-1:0];
      end else begin
         tap = diff[ADDR_W-1:0];
      end
   end

endmodule

// File: hdl/stereo_cross_feedback_comb_delay.sv
// ----------------------------------------------------------------------------
// stereo_cross_feedback_comb_delay
// Path: a request passes stage registers 1 to 5, then the output register.
// Throughput: one request per cycle while the response is not stalled; a tap
// on the immediately preceding request stalls stage 2 (line read, multiply, round loop).
// Reset: synchronous; control registers cleared, datapath registers not, lines
// read as zero until written (write-position fill tracking, no clearing pass).
// ----------------------------------------------------------------------------
module stereo_cross_feedback_comb_delay import sxcd_pkg::*; #(
   parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int                ADDR_W    = $clog2(LINE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_DEPTH - 1);

   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
      return (a == LAST_ADDR) ? '0 : a + 1'b1;
   endfunction

   cfg_type cfg;

   // control
   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic              fresh_ff, wrapped_ff, w_valid_ff;
   logic [ADDR_W-1:0] wp_ff, cp_ff;
   logic              mv1, mv2, mv3, mv4, mv5;
   logic              rdy1, rdy2, rdy3, rdy4, rdy5, out_free, hazard2, accept;

   // stage 1
   sample_type        x_l1_ff, x_r1_ff;
   logic [ADDR_W-1:0] wp1_ff, tap_l1, tap_r1;
   logic              unw_l1, unw_r1;

   // stage 2
   sample_type        x_l2_ff, x_r2_ff, hold_l_ff, hold_r_ff, rd_l, rd_r;
   sample_type        base_l, base_r, eff_l, eff_r;
   logic [ADDR_W-1:0] wp2_ff, tap_l2_ff, tap_r2_ff;
   logic              unw_l2_ff, unw_r2_ff;

   // stage 3
   sample_type        x_l3_ff, x_r3_ff;
   logic [ADDR_W-1:0] wp3_ff;
   prod_type          fbl_a_ff, fbl_b_ff, fbr_a_ff, fbr_b_ff;
   prod_type          ffl_a_ff, ffl_b_ff, ffr_a_ff, ffr_b_ff;

   // stage 4
   sample_type        nl4_ff, nr4_ff;
   logic [ADDR_W-1:0] wp4_ff;
   acc_type           ffsum_l4_ff, ffsum_r4_ff;

   // stage 5
   prod_type          bl5_ff, br5_ff;
   acc_type           ffsum_l5_ff, ffsum_r5_ff;

   // last committed line write
   logic [ADDR_W-1:0] w_addr_ff;
   sample_type        w_left_ff, w_right_ff;

   rsp_type           rsp_data_ff;

   sxcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sxcd_tap_gen #(.DEPTH(LINE_DEPTH)) u_tap_left (
      .clock (clock),
      .load  (accept),
      .delay (cfg.delay_left),
      .wp    (wp1_ff),
      .tap   (tap_l1)
   );

   sxcd_tap_gen #(.DEPTH(LINE_DEPTH)) u_tap_right (
      .clock (clock),
      .load  (accept),
      .delay (cfg.delay_right),
      .wp    (wp1_ff),
      .tap   (tap_r1)
   );

   sxcd_line_ram #(.DEPTH(LINE_DEPTH)) u_line_left (
      .clock   (clock),
      .wr_en   (mv4),
      .wr_addr (wp4_ff),
      .wr_data (nl4_ff),
      .rd_en   (mv1),
      .rd_addr (tap_l1),
      .rd_data (rd_l)
   );

   sxcd_line_ram #(.DEPTH(LINE_DEPTH)) u_line_right (
      .clock   (clock),
      .wr_en   (mv4),
      .wr_addr (wp4_ff),
      .wr_data (nr4_ff),
      .rd_en   (mv1),
      .rd_addr (tap_r1),
      .rd_data (rd_r)
   );

   // pipeline flow
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      mv5      = v5_ff && out_free;
      rdy5     = !v5_ff || mv5;
      mv4      = v4_ff && rdy5;
      rdy4     = !v4_ff || mv4;
      mv3      = v3_ff && rdy4;
      rdy3     = !v3_ff || mv3;
      hazard2  = v3_ff && (wp3_ff == tap_l2_ff || wp3_ff == tap_r2_ff);
      mv2      = v2_ff && rdy3 && !hazard2;
      rdy2     = !v2_ff || mv2;
      mv1      = v1_ff && rdy2;
      rdy1     = !v1_ff || mv1;
      accept   = req_valid && rdy1;
   end

   assign req_stall = !rdy1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // entries beyond the committed write position read as zero until wrap
   assign unw_l1 = !wrapped_ff && (tap_l1 >= cp_ff);
   assign unw_r1 = !wrapped_ff && (tap_r1 >= cp_ff);

   // delayed values: the pending write wins, then the last commit, then memory
   always_comb begin
      if (fresh_ff) begin
         base_l = unw_l2_ff ? '0 : rd_l;
         base_r = unw_r2_ff ? '0 : rd_r;
      end else begin
         base_l = hold_l_ff;
         base_r = hold_r_ff;
      end
      priority if (v4_ff && wp4_ff == tap_l2_ff) begin
         eff_l = nl4_ff;
      end else if (w_valid_ff && w_addr_ff == tap_l2_ff) begin
         eff_l = w_left_ff;
      end else begin
         eff_l = base_l;
      end
      priority if (v4_ff && wp4_ff == tap_r2_ff) begin
         eff_r = nr4_ff;
      end else if (w_valid_ff && w_addr_ff == tap_r2_ff) begin
         eff_r = w_right_ff;
      end else begin
         eff_r = base_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= 1'b0;
         wrapped_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
         wp_ff        <= '0;
         cp_ff        <= '0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= mv1;
         end
         if (rdy3) begin
            v3_ff <= mv2;
         end
         if (rdy4) begin
            v4_ff <= mv3;
         end
         if (rdy5) begin
            v5_ff <= mv4;
         end
         if (out_free) begin
            rsp_valid_ff <= v5_ff;
         end
         fresh_ff <= mv1;
         if (accept) begin
            wp_ff <= next_addr(wp_ff);
         end
         if (mv4) begin
            w_valid_ff <= 1'b1;
            cp_ff      <= next_addr(wp4_ff);
            if (wp4_ff == LAST_ADDR) begin
               wrapped_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_l1_ff <= req_data.in_left;
         x_r1_ff <= req_data.in_right;
         wp1_ff  <= wp_ff;
      end
      if (mv1) begin
         x_l2_ff   <= x_l1_ff;
         x_r2_ff   <= x_r1_ff;
         wp2_ff    <= wp1_ff;
         tap_l2_ff <= tap_l1;
         tap_r2_ff <= tap_r1;
         unw_l2_ff <= unw_l1;
         unw_r2_ff <= unw_r1;
      end
      if (v2_ff) begin
         hold_l_ff <= eff_l;
         hold_r_ff <= eff_r;
      end
      if (mv2) begin
         x_l3_ff  <= x_l2_ff;
         x_r3_ff  <= x_r2_ff;
         wp3_ff   <= wp2_ff;
         fbl_a_ff <= coef_hi(cfg.fb_left) * eff_l;
         fbl_b_ff <= coef_lo(cfg.fb_left) * eff_r;
         fbr_a_ff <= coef_hi(cfg.fb_right) * eff_l;
         fbr_b_ff <= coef_lo(cfg.fb_right) * eff_r;
         ffl_a_ff <= coef_hi(cfg.ff_left) * eff_l;
         ffl_b_ff <= coef_lo(cfg.ff_left) * eff_r;
         ffr_a_ff <= coef_hi(cfg.ff_right) * eff_l;
         ffr_b_ff <= coef_lo(cfg.ff_right) * eff_r;
      end
      if (mv3) begin
         wp4_ff      <= wp3_ff;
         nl4_ff      <= round_sat((acc_type'(x_l3_ff) <<< FRAC_W)
                                  + acc_type'(fbl_a_ff) + acc_type'(fbl_b_ff));
         nr4_ff      <= round_sat((acc_type'(x_r3_ff) <<< FRAC_W)
                                  + acc_type'(fbr_a_ff) + acc_type'(fbr_b_ff));
         ffsum_l4_ff <= acc_type'(ffl_a_ff) + acc_type'(ffl_b_ff);
         ffsum_r4_ff <= acc_type'(ffr_a_ff) + acc_type'(ffr_b_ff);
      end
      if (mv4) begin
         w_addr_ff   <= wp4_ff;
         w_left_ff   <= nl4_ff;
         w_right_ff  <= nr4_ff;
         bl5_ff      <= $signed(cfg.blend_left) * nl4_ff;
         br5_ff      <= $signed(cfg.blend_right) * nr4_ff;
         ffsum_l5_ff <= ffsum_l4_ff;
         ffsum_r5_ff <= ffsum_r4_ff;
      end
      if (mv5) begin
         rsp_data_ff.out_left  <= round_sat(acc_type'(bl5_ff) + ffsum_l5_ff);
         rsp_data_ff.out_right <= round_sat(acc_type'(br5_ff) + ffsum_r5_ff);
      end
   end

endmodule
